// ===== src/prts_pkg.sv =====
package prts_pkg;

    // Width of a page number as carried on the channels.
    localparam int unsigned PAGE_W = 12;

    // Default table depth.
    localparam int unsigned NUM_PAGES_DEF = 4096;

    // Operation codes of the func field.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_SWAP   = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WR0,
        S_WR1,
        S_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // take the accepted transaction into the item registers
        logic rd;         // read both tables at page_a and page_b
        logic wr;         // write-back step of a swap
        logic wr_second;  // selects the second pair of writes
        logic clr;        // write one identity entry of the clearing pass
        logic load_out;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // clearing pass is at its last entry
        logic out_free;   // result register can take a new result this cycle
    } t_status;

endpackage

// ===== src/prts_if.sv =====
// Request channel: one lookup or swap transaction.
interface prts_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [prts_pkg::PAGE_W-1:0] page_a;
    logic [prts_pkg::PAGE_W-1:0] page_b;
    logic                        by_virtual;

    modport source (output valid, func, page_a, page_b, by_virtual, input ready);
    modport sink   (input valid, func, page_a, page_b, by_virtual, output ready);
endinterface

// Response channel: one result transaction per request.
interface prts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [prts_pkg::PAGE_W-1:0] phys_page;
    logic                        swapped;

    modport source (output valid, phys_page, swapped, input ready);
    modport sink   (input valid, phys_page, swapped, output ready);
endinterface

// ===== src/prts_ctrl.sv =====
module prts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  prts_pkg::t_status i_status,
    output prts_pkg::t_cmd    o_cmd
);
    import prts_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR0;
            end
            S_WR0: begin
                o_cmd.wr = 1'b1;
                n_state  = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr        = 1'b1;
                o_cmd.wr_second = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A swap never writes the tables before the clearing pass is over.
    a_no_early_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> $past(r_state) != S_CLEAR || $past(i_status.clr_last))
        else $error("table write during clearing pass");

    // An accepted transaction always leads to a table read in the next cycle.
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> o_cmd.rd)
        else $error("accepted transaction not followed by a read");

endmodule

// ===== src/prts_dp.sv =====
module prts_dp #(
    parameter int unsigned NUM_PAGES = prts_pkg::NUM_PAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prts_pkg::t_cmd              i_cmd,
    output prts_pkg::t_status           o_status,
    input  logic                        i_func,
    input  logic [prts_pkg::PAGE_W-1:0] i_page_a,
    input  logic [prts_pkg::PAGE_W-1:0] i_page_b,
    input  logic                        i_by_virtual,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [prts_pkg::PAGE_W-1:0] o_phys_page,
    output logic                        o_swapped
);
    import prts_pkg::*;

    localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PAGES - 1);

    // Forward map (virtual to physical) and reverse map (physical to virtual).
    logic [AW-1:0] fwd_mem [NUM_PAGES];
    logic [AW-1:0] rev_mem [NUM_PAGES];

    // Item registers.
    logic          r_func;
    logic          r_virt;
    logic          r_ok;
    logic [AW-1:0] r_pa;
    logic [AW-1:0] r_pb;

    // Registered read data.
    logic [AW-1:0] r_fwd_a;
    logic [AW-1:0] r_fwd_b;
    logic [AW-1:0] r_rev_a;
    logic [AW-1:0] r_rev_b;

    logic [AW-1:0] r_clr_cnt;

    logic          r_out_valid;
    logic [PAGE_W-1:0] r_out_phys;
    logic          r_out_swapped;

    logic          a_in_range;
    logic          b_in_range;
    logic          n_ok;
    logic [AW-1:0] v1;
    logic [AW-1:0] v2;
    logic [AW-1:0] p1;
    logic [AW-1:0] p2;
    logic          tab_we;
    logic [AW-1:0] fwd_waddr;
    logic [AW-1:0] fwd_wdata;
    logic [AW-1:0] rev_waddr;
    logic [AW-1:0] rev_wdata;

    // Range and equality checks on the incoming transaction.
    assign a_in_range = 32'(i_page_a) < 32'(NUM_PAGES);
    assign b_in_range = 32'(i_page_b) < 32'(NUM_PAGES);
    assign n_ok = (i_func == FUNC_LOOKUP) ? a_in_range
                : (a_in_range && b_in_range && (i_page_a != i_page_b));

    // Capture the transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_virt <= i_by_virtual;
            r_ok   <= n_ok;
            r_pa   <= AW'(i_page_a);
            r_pb   <= AW'(i_page_b);
        end
    end

    // The tables are always inverse permutations, so a virtual page owns the
    // frame it maps to. For named virtual pages the owners are the pages
    // themselves; for named physical pages the frames are the pages.
    always_comb begin
        if (r_virt) begin
            v1 = r_pa;
            v2 = r_pb;
            p1 = r_fwd_a;
            p2 = r_fwd_b;
        end else begin
            v1 = r_rev_a;
            v2 = r_rev_b;
            p1 = r_pa;
            p2 = r_pb;
        end
    end

    // Write address and data: identity during the clearing pass, otherwise
    // the two exchange steps of a swap.
    always_comb begin
        tab_we = i_cmd.clr || (i_cmd.wr && r_ok && (r_func == FUNC_SWAP));
        if (i_cmd.clr) begin
            fwd_waddr = r_clr_cnt;
            fwd_wdata = r_clr_cnt;
            rev_waddr = r_clr_cnt;
            rev_wdata = r_clr_cnt;
        end else if (i_cmd.wr_second) begin
            fwd_waddr = v2;
            fwd_wdata = p1;
            rev_waddr = p2;
            rev_wdata = v1;
        end else begin
            fwd_waddr = v1;
            fwd_wdata = p2;
            rev_waddr = p1;
            rev_wdata = v2;
        end
    end

    // Table memories: one write port and two read ports each.
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
            rev_mem[rev_waddr] <= rev_wdata;
        end
        if (i_cmd.rd) begin
            r_fwd_a <= fwd_mem[r_pa];
            r_fwd_b <= fwd_mem[r_pb];
            r_rev_a <= rev_mem[r_pa];
            r_rev_b <= rev_mem[r_pb];
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr && (r_clr_cnt != LAST_IDX)) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_phys    <= (r_ok && (r_func == FUNC_LOOKUP)) ? PAGE_W'(r_fwd_a) : '0;
            r_out_swapped <= r_ok && (r_func == FUNC_SWAP);
        end
    end

    assign o_status.clr_last = (r_clr_cnt == LAST_IDX);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_phys_page       = r_out_phys;
    assign o_swapped         = r_out_swapped;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // A swap write-back always exchanges two distinct pages.
    a_swap_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && tab_we) |-> (r_pa != r_pb) && (v1 != v2) && (p1 != p2))
        else $error("swap write-back on equal pages");

    // A swap result never carries a page number.
    a_swap_zero_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_swapped) |-> (r_out_phys == '0))
        else $error("swap result with nonzero page");

endmodule

// ===== src/page_remap_table_swap_top.sv =====
// Page remap table with swap. The block holds a forward map from virtual to
// physical page and its reverse map, both reset to the identity. A lookup
// transaction returns the physical page of page_a; a swap transaction
// exchanges the frames of two pages (named as virtual or as physical pages)
// in both maps and reports swapped = 1 when the tables changed. A request
// passes through acceptance, the registered read of both tables in S_READ,
// and the write-back states S_WR0 and S_WR1, since each table memory has a
// single write port and a swap writes two entries of each. One request is in
// flight at a time; the next is accepted while the previous result waits in
// the output register. After reset a clearing pass writes the identity into
// both tables, one entry per cycle, during which no request is accepted.
module page_remap_table_swap_top #(
    parameter int unsigned NUM_PAGES = prts_pkg::NUM_PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prts_req_if.sink   i_req,
    prts_rsp_if.source o_rsp
);
    import prts_pkg::*;

    t_cmd    cmd;
    t_status status;

    prts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    prts_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_req.func),
        .i_page_a     (i_req.page_a),
        .i_page_b     (i_req.page_b),
        .i_by_virtual (i_req.by_virtual),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_phys_page  (o_rsp.phys_page),
        .o_swapped    (o_rsp.swapped)
    );

endmodule

// ===== test/page_remap_table_swap_top_test.sv =====
module page_remap_table_swap_top_test;
    import prts_pkg::*;

    localparam int unsigned TB_PAGES     = NUM_PAGES_DEF;
    localparam int unsigned RAND_ITEMS   = 1950;
    localparam int unsigned NUM_PHASES   = 4;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned NUM_DIR_ROWS = 24;

    // Percent of cycles the sender idles and the receiver stalls, per phase.
    localparam int GAP_PCT   [NUM_PHASES] = '{0, 61, 0, 9};
    localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 61, 9};

    typedef struct packed {
        logic              func;
        logic [PAGE_W-1:0] page_a;
        logic [PAGE_W-1:0] page_b;
        logic              by_virtual;
    } t_remap_req;

    typedef struct packed {
        logic [PAGE_W-1:0] phys_page;
        logic              swapped;
    } t_remap_rsp;

    // One directed row: the request, and a typed-in result where known is set.
    typedef struct packed {
        t_remap_req req;
        logic       known;
        t_remap_rsp rsp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    prts_req_if req_ch ();
    prts_rsp_if rsp_ch ();

    page_remap_table_swap_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Local copy of both maps, kept in step with accepted transactions.
    logic [PAGE_W-1:0] fwd_tbl [TB_PAGES];
    logic [PAGE_W-1:0] rev_tbl [TB_PAGES];

    t_remap_rsp  pending_rsp [$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;

    // Directed rows: reset identity, extremes, equal pages, both naming modes.
    t_dir_row dir_rows [NUM_DIR_ROWS] = '{
        '{'{FUNC_LOOKUP, 12'h000, 12'h000, 1'b0}, 1'b1, '{12'h000, 1'b0}},
        '{'{FUNC_LOOKUP, 12'hFFF, 12'hFFF, 1'b0}, 1'b1, '{12'hFFF, 1'b0}},
        '{'{FUNC_LOOKUP, 12'h555, 12'hAAA, 1'b1}, 1'b1, '{12'h555, 1'b0}},
        '{'{FUNC_LOOKUP, 12'hAAA, 12'h555, 1'b0}, 1'b1, '{12'hAAA, 1'b0}},
        '{'{FUNC_SWAP,   12'h000, 12'hFFF, 1'b1}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_LOOKUP, 12'h000, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_LOOKUP, 12'hFFF, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_SWAP,   12'h000, 12'hFFF, 1'b0}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_LOOKUP, 12'h000, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_SWAP,   12'h007, 12'h007, 1'b1}, 1'b1, '{12'h000, 1'b0}},
        '{'{FUNC_SWAP,   12'hFFF, 12'hFFF, 1'b0}, 1'b1, '{12'h000, 1'b0}},
        '{'{FUNC_SWAP,   12'h000, 12'h000, 1'b0}, 1'b1, '{12'h000, 1'b0}},
        '{'{FUNC_SWAP,   12'h001, 12'h002, 1'b1}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_SWAP,   12'h001, 12'h003, 1'b0}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_SWAP,   12'h002, 12'h003, 1'b1}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_LOOKUP, 12'h001, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_LOOKUP, 12'h002, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_LOOKUP, 12'h003, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_SWAP,   12'h555, 12'hAAA, 1'b1}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_SWAP,   12'hAAA, 12'h555, 1'b0}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_LOOKUP, 12'h555, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_LOOKUP, 12'hAAA, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}},
        '{'{FUNC_SWAP,   12'h800, 12'h7FF, 1'b0}, 1'b1, '{12'h000, 1'b1}},
        '{'{FUNC_LOOKUP, 12'h7FF, 12'h000, 1'b0}, 1'b0, '{12'h000, 1'b0}}
    };

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Free-running cycle count for the timeout.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Works out the result of one transaction and applies it to the local maps.
    function automatic t_remap_rsp remap_predict(input t_remap_req r);
        t_remap_rsp        res;
        logic [PAGE_W-1:0] p1, p2, v1, v2, f1, f2;
        res = '0;
        if (r.func == FUNC_LOOKUP) begin
            if (r.page_a < TB_PAGES) begin
                res.phys_page = fwd_tbl[r.page_a];
            end
        end else if (r.page_a != r.page_b && r.page_a < TB_PAGES &&
                     r.page_b < TB_PAGES) begin
            // Virtual names are translated to frames first.
            p1 = r.by_virtual ? fwd_tbl[r.page_a] : r.page_a;
            p2 = r.by_virtual ? fwd_tbl[r.page_b] : r.page_b;
            v1 = rev_tbl[p1];
            v2 = rev_tbl[p2];
            f1 = fwd_tbl[v1];
            f2 = fwd_tbl[v2];
            fwd_tbl[v1] = f2;
            fwd_tbl[v2] = f1;
            rev_tbl[p1] = v2;
            rev_tbl[p2] = v1;
            res.swapped = 1'b1;
        end
        return res;
    endfunction

    // Page choice that favors a small pool, so pages get swapped many times over.
    function automatic logic [PAGE_W-1:0] pick_page();
        logic [PAGE_W-1:0] pg;
        case ($urandom_range(3))
            0: begin
                pg = PAGE_W'($urandom_range(15));
            end
            1: begin
                pg = PAGE_W'(TB_PAGES - 1 - $urandom_range(3));
            end
            default: begin
                pg = PAGE_W'($urandom());
            end
        endcase
        return pg;
    endfunction

    function automatic t_remap_req random_req();
        t_remap_req r;
        r.func       = ($urandom_range(99) < 55) ? FUNC_SWAP : FUNC_LOOKUP;
        r.page_a     = pick_page();
        r.page_b     = ($urandom_range(11) == 0) ? r.page_a : pick_page();
        r.by_virtual = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input t_remap_rsp want,
                                            input t_remap_rsp got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch (%s) at cycle %0d: expected phys_page=%h swapped=%b,",
                     what, cycle_cnt, want.phys_page, want.swapped);
            $display("    got phys_page=%h swapped=%b", got.phys_page, got.swapped);
        end
    endfunction

    // Presents one request, holds it until accepted, then records its result.
    task automatic send_req(input t_remap_req r, input logic known, input t_remap_rsp typed);
        t_remap_rsp predicted;
        while ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= r.func;
        req_ch.page_a     <= r.page_a;
        req_ch.page_b     <= r.page_b;
        req_ch.by_virtual <= r.by_virtual;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        predicted   = remap_predict(r);
        pending_rsp = {pending_rsp, (known ? typed : predicted)};
    endtask

    // Response side: check each transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_remap_rsp got;
        t_remap_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.phys_page = rsp_ch.phys_page;
                got.swapped   = rsp_ch.swapped;
                if (pending_rsp.size() == 0) begin
                    report_mismatch("unexpected", '0, got);
                end else begin
                    want = pending_rsp.pop_front();
                    if (got.phys_page !== want.phys_page || got.swapped !== want.swapped) begin
                        report_mismatch("field", want, got);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Main sequence: reset, directed rows, then random phases.
    initial begin
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_LOOKUP;
        req_ch.page_a     <= '0;
        req_ch.page_b     <= '0;
        req_ch.by_virtual <= 1'b0;
        for (int i = 0; i < TB_PAGES; i++) begin
            fwd_tbl[i] = PAGE_W'(i);
            rev_tbl[i] = PAGE_W'(i);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            gap_pct   = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            repeat (RAND_ITEMS / NUM_PHASES) begin
                send_req(random_req(), 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones.
        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("page_remap_table_swap_top_test passed");
        end else begin
            $display("page_remap_table_swap_top_test failed");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("page_remap_table_swap_top_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/prts_pkg.sv
src/prts_if.sv
src/prts_ctrl.sv
src/prts_dp.sv
src/page_remap_table_swap_top.sv
test/page_remap_table_swap_top_test.sv
